### hw/rtl/swsr_pkg.sv
// Shared constants, register indexes and types of the single-wire sensor reader.
package swsr_pkg;

    // Width of the microsecond counter; it saturates at its all-ones value.
    localparam int COUNTER_BITS = 21;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    // Width used for comparing the counter against a delay.
    localparam int CMP_W = 32;

    // Field widths of the configuration registers.
    localparam int PRE_W   = 21;
    localparam int DELAY_W = 16;
    localparam int FRAME_W = 4;

    // APB address width: seven registers at byte address 4*i.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (word address within the port).
    typedef enum logic [2:0] {
        REG_PRE_IDLE     = 3'd0,
        REG_START_LOW    = 3'd1,
        REG_RELEASE_HIGH = 3'd2,
        REG_FIRST_CHECK  = 3'd3,
        REG_SECOND_CHECK = 3'd4,
        REG_BIT_SAMPLE   = 3'd5,
        REG_BYTES_FRAME  = 3'd6
    } t_reg_idx;

    // Reset values of the registers.
    localparam logic [PRE_W-1:0]   RST_PRE_IDLE     = 21'd1500000;
    localparam logic [DELAY_W-1:0] RST_START_LOW    = 16'd18000;
    localparam logic [DELAY_W-1:0] RST_RELEASE_HIGH = 16'd20;
    localparam logic [DELAY_W-1:0] RST_FIRST_CHECK  = 16'd40;
    localparam logic [DELAY_W-1:0] RST_SECOND_CHECK = 16'd80;
    localparam logic [DELAY_W-1:0] RST_BIT_SAMPLE   = 16'd40;
    localparam logic [FRAME_W-1:0] RST_BYTES_FRAME  = 4'd5;

    // Response status codes.
    localparam logic [1:0] STATUS_ABSENT = 2'd0;
    localparam logic [1:0] STATUS_OK     = 2'd1;
    localparam logic [1:0] STATUS_BAD    = 2'd2;

    // Configuration as seen by the sequencer.
    typedef struct packed {
        logic [PRE_W-1:0]   pre_idle_us;
        logic [DELAY_W-1:0] start_low_us;
        logic [DELAY_W-1:0] release_high_us;
        logic [DELAY_W-1:0] first_check_us;
        logic [DELAY_W-1:0] second_check_us;
        logic [DELAY_W-1:0] bit_sample_us;
        logic [FRAME_W-1:0] bytes_per_frame;
    } t_cfg;

    // One result word.
    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic       response_valid;
        logic [1:0] response_status;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
        logic       busy_res;
    } t_result;

endpackage

### hw/rtl/swsr_regs.sv
// APB register file holding the timing and frame configuration.
module swsr_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swsr_pkg::ADDR_W-1:0]  paddr,
    input  logic [swsr_pkg::DATA_W-1:0]  pwdata,
    output logic [swsr_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output swsr_pkg::t_cfg               o_cfg
);

    swsr_pkg::t_cfg   r_cfg;
    swsr_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = swsr_pkg::t_reg_idx'(paddr[swsr_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes in the access cycle; addresses beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_idle_us     <= swsr_pkg::RST_PRE_IDLE;
            r_cfg.start_low_us    <= swsr_pkg::RST_START_LOW;
            r_cfg.release_high_us <= swsr_pkg::RST_RELEASE_HIGH;
            r_cfg.first_check_us  <= swsr_pkg::RST_FIRST_CHECK;
            r_cfg.second_check_us <= swsr_pkg::RST_SECOND_CHECK;
            r_cfg.bit_sample_us   <= swsr_pkg::RST_BIT_SAMPLE;
            r_cfg.bytes_per_frame <= swsr_pkg::RST_BYTES_FRAME;
        end else if (w_wr) begin
            case (w_idx)
                swsr_pkg::REG_PRE_IDLE:
                    r_cfg.pre_idle_us <= pwdata[swsr_pkg::PRE_W-1:0];
                swsr_pkg::REG_START_LOW:
                    r_cfg.start_low_us <= pwdata[swsr_pkg::DELAY_W-1:0];
                swsr_pkg::REG_RELEASE_HIGH:
                    r_cfg.release_high_us <= pwdata[swsr_pkg::DELAY_W-1:0];
                swsr_pkg::REG_FIRST_CHECK:
                    r_cfg.first_check_us <= pwdata[swsr_pkg::DELAY_W-1:0];
                swsr_pkg::REG_SECOND_CHECK:
                    r_cfg.second_check_us <= pwdata[swsr_pkg::DELAY_W-1:0];
                swsr_pkg::REG_BIT_SAMPLE:
                    r_cfg.bit_sample_us <= pwdata[swsr_pkg::DELAY_W-1:0];
                swsr_pkg::REG_BYTES_FRAME:
                    r_cfg.bytes_per_frame <= pwdata[swsr_pkg::FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data, zero-extended to the bus width.
    always_comb begin
        prdata = '0;
        case (w_idx)
            swsr_pkg::REG_PRE_IDLE:
                prdata = swsr_pkg::DATA_W'(r_cfg.pre_idle_us);
            swsr_pkg::REG_START_LOW:
                prdata = swsr_pkg::DATA_W'(r_cfg.start_low_us);
            swsr_pkg::REG_RELEASE_HIGH:
                prdata = swsr_pkg::DATA_W'(r_cfg.release_high_us);
            swsr_pkg::REG_FIRST_CHECK:
                prdata = swsr_pkg::DATA_W'(r_cfg.first_check_us);
            swsr_pkg::REG_SECOND_CHECK:
                prdata = swsr_pkg::DATA_W'(r_cfg.second_check_us);
            swsr_pkg::REG_BIT_SAMPLE:
                prdata = swsr_pkg::DATA_W'(r_cfg.bit_sample_us);
            swsr_pkg::REG_BYTES_FRAME:
                prdata = swsr_pkg::DATA_W'(r_cfg.bytes_per_frame);
            default: prdata = '0;
        endcase
    end

endmodule

### hw/rtl/swsr_seq.sv
// Line sequencer: start pulse, response check and bit reception, one sample a step.
module swsr_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  swsr_pkg::t_cfg      i_cfg,
    input  logic                i_start_req,
    input  logic                i_tick,
    input  logic                i_pin_level,
    output swsr_pkg::t_result   o_res
);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_PRE       = 4'd1,
        PH_LOW       = 4'd2,
        PH_REL       = 4'd3,
        PH_CHK1      = 4'd4,
        PH_CHK2      = 4'd5,
        PH_WAIT_OK   = 4'd6,
        PH_WAIT_END  = 4'd7,
        PH_BIT_HIGH  = 4'd8,
        PH_BIT_DELAY = 4'd9,
        PH_BIT_LOW   = 4'd10
    } t_phase;

    t_phase                            r_phase, n_phase;
    logic [swsr_pkg::COUNTER_BITS-1:0] r_cnt, n_cnt, w_cnt_inc;
    logic [7:0]                        r_shift, n_shift;
    logic [2:0]                        r_bit_idx, n_bit_idx;
    logic [2:0]                        r_byte_idx, n_byte_idx;
    logic [swsr_pkg::PRE_W-1:0]        w_target;
    logic                              w_done;
    logic [3:0]                        w_frame;
    logic [3:0]                        w_next_byte;
    swsr_pkg::t_result                 w_res;

    // Byte count clamped into one to eight.
    always_comb begin
        if (i_cfg.bytes_per_frame == 4'd0) begin
            w_frame = 4'd1;
        end else if (i_cfg.bytes_per_frame > 4'd8) begin
            w_frame = 4'd8;
        end else begin
            w_frame = i_cfg.bytes_per_frame;
        end
    end

    // Delay of the current timed phase.
    always_comb begin
        case (r_phase)
            PH_PRE:       w_target = i_cfg.pre_idle_us;
            PH_LOW:       w_target = swsr_pkg::PRE_W'(i_cfg.start_low_us);
            PH_REL:       w_target = swsr_pkg::PRE_W'(i_cfg.release_high_us);
            PH_CHK1:      w_target = swsr_pkg::PRE_W'(i_cfg.first_check_us);
            PH_CHK2:      w_target = swsr_pkg::PRE_W'(i_cfg.second_check_us);
            PH_BIT_DELAY: w_target = swsr_pkg::PRE_W'(i_cfg.bit_sample_us);
            default:      w_target = '0;
        endcase
    end

    // Saturating tick count; a delay beyond the counter range ends at saturation.
    assign w_cnt_inc = (i_tick && (r_cnt != swsr_pkg::CNT_MAX)) ?
                       r_cnt + 1'b1 : r_cnt;
    assign w_done = (swsr_pkg::CMP_W'(w_cnt_inc) >= swsr_pkg::CMP_W'(w_target)) ||
                    (w_cnt_inc == swsr_pkg::CNT_MAX);
    assign w_next_byte = {1'b0, r_byte_idx} + 4'd1;

    // Next state and the result word of this sample.
    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_shift    = r_shift;
        n_bit_idx  = r_bit_idx;
        n_byte_idx = r_byte_idx;
        w_res      = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_phase = PH_PRE;
                    n_cnt   = '0;
                end
            end
            PH_PRE, PH_LOW, PH_REL: begin
                n_cnt = w_cnt_inc;
                if (w_done) begin
                    n_cnt = '0;
                    case (r_phase)
                        PH_PRE:  n_phase = PH_LOW;
                        PH_LOW:  n_phase = PH_REL;
                        default: n_phase = PH_CHK1;
                    endcase
                end
            end
            PH_CHK1: begin
                n_cnt = w_cnt_inc;
                if (w_done) begin
                    n_cnt = '0;
                    if (i_pin_level) begin
                        // Line still high: no sensor answered.
                        w_res.response_valid  = 1'b1;
                        w_res.response_status = swsr_pkg::STATUS_ABSENT;
                        n_phase = PH_WAIT_END;
                    end else begin
                        n_phase = PH_CHK2;
                    end
                end
            end
            PH_CHK2: begin
                n_cnt = w_cnt_inc;
                if (w_done) begin
                    n_cnt = '0;
                    w_res.response_valid = 1'b1;
                    if (i_pin_level) begin
                        w_res.response_status = swsr_pkg::STATUS_OK;
                        n_phase = PH_WAIT_OK;
                    end else begin
                        w_res.response_status = swsr_pkg::STATUS_BAD;
                        n_phase = PH_WAIT_END;
                    end
                end
            end
            PH_WAIT_OK: begin
                if (!i_pin_level) begin
                    n_shift    = '0;
                    n_bit_idx  = '0;
                    n_byte_idx = '0;
                    n_phase    = PH_BIT_HIGH;
                    n_cnt      = '0;
                end
            end
            PH_WAIT_END: begin
                if (!i_pin_level) begin
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                end
            end
            PH_BIT_HIGH: begin
                if (i_pin_level) begin
                    n_phase = PH_BIT_DELAY;
                    n_cnt   = '0;
                end
            end
            PH_BIT_DELAY: begin
                n_cnt = w_cnt_inc;
                if (w_done) begin
                    n_cnt   = '0;
                    n_shift = {r_shift[6:0], i_pin_level};
                    n_phase = PH_BIT_LOW;
                end
            end
            PH_BIT_LOW: begin
                if (!i_pin_level) begin
                    n_cnt   = '0;
                    n_phase = PH_BIT_HIGH;
                    if (r_bit_idx == 3'd7) begin
                        // Falling edge after the eighth bit closes the byte.
                        w_res.byte_valid = 1'b1;
                        w_res.data_byte  = r_shift;
                        w_res.last_byte  = (w_next_byte >= w_frame);
                        n_bit_idx = '0;
                        n_shift   = '0;
                        if (w_next_byte >= w_frame) begin
                            n_byte_idx = '0;
                            n_phase    = PH_IDLE;
                        end else begin
                            n_byte_idx = w_next_byte[2:0];
                        end
                    end else begin
                        n_bit_idx = r_bit_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
            end
        endcase

        // Line drive and busy follow the phase after this sample.
        w_res.drive_enable = (n_phase == PH_PRE) || (n_phase == PH_REL) ||
                             (n_phase == PH_LOW);
        w_res.drive_level  = (n_phase == PH_PRE) || (n_phase == PH_REL);
        w_res.busy_res     = (n_phase != PH_IDLE);
    end

    assign o_res = w_res;

    // State advances only on an accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cnt      <= '0;
            r_shift    <= '0;
            r_bit_idx  <= '0;
            r_byte_idx <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_shift    <= n_shift;
            r_bit_idx  <= n_bit_idx;
            r_byte_idx <= n_byte_idx;
        end
    end

endmodule

### hw/rtl/single_wire_sensor_reader_top.sv
// Top level of the single-wire sensor reader: handshake, result register and checks.
//
// Each input word is one sample of the data line with a start request and a
// microsecond tick; each accepted word yields exactly one result word with the
// line drive, response status, received byte and busy flag.
// Input channel: i_valid / o_stall. Output channel: o_valid / i_stall.
// A word is taken at a clock edge with valid high and stall low.
// The result of a word sits in the output register on the cycle after it is
// accepted. Throughput is one word per cycle while the receiver does not stall,
// set by the phase update between the state registers and the result
// register; a new word is taken while the previous result is being taken.
// When the receiver stalls, the result is held and o_stall rises, so no
// further sample is taken until the result leaves.
// Configuration is written through the APB port (seven registers at byte address
// 4*i) by the user while the link is idle (unenforced); pready is always high.
// Synchronous active-low reset returns the sequencer to idle, clears the
// counters and the output register, and loads the register defaults.
module single_wire_sensor_reader_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_start_req,
    input  logic                         i_tick,
    input  logic                         i_pin_level,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_drive_enable,
    output logic                         o_drive_level,
    output logic                         o_response_valid,
    output logic [1:0]                   o_response_status,
    output logic [7:0]                   o_data_byte,
    output logic                         o_byte_valid,
    output logic                         o_last_byte,
    output logic                         o_busy_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swsr_pkg::ADDR_W-1:0]  paddr,
    input  logic [swsr_pkg::DATA_W-1:0]  pwdata,
    output logic [swsr_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    swsr_pkg::t_cfg    w_cfg;
    swsr_pkg::t_result w_res;
    swsr_pkg::t_result r_out;
    logic              r_out_valid;
    logic              w_accept;

    // Configuration registers.
    swsr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The input is held off only while a result waits on a stalled receiver.
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    // Sequencer.
    swsr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_accept),
        .i_cfg       (w_cfg),
        .i_start_req (i_start_req),
        .i_tick      (i_tick),
        .i_pin_level (i_pin_level),
        .o_res       (w_res)
    );

    // Output register: loaded on every accepted word, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
            r_out       <= w_res;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_drive_enable    = r_out.drive_enable;
    assign o_drive_level     = r_out.drive_level;
    assign o_response_valid  = r_out.response_valid;
    assign o_response_status = r_out.response_status;
    assign o_data_byte       = r_out.data_byte;
    assign o_byte_valid      = r_out.byte_valid;
    assign o_last_byte       = r_out.last_byte;
    assign o_busy_res        = r_out.busy_res;

    // An accepted word always leaves a result in the output register.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted word produced no result");

    // A stalled result is not overwritten by a new sample.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data_byte) &&
                                  $stable(o_busy_res)))
        else $error("result changed while the receiver stalled");

    // The last byte of a frame returns the link to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_byte) |-> (o_byte_valid && !o_busy_res))
        else $error("last byte without byte valid or while busy");

    // The line is never driven once the link is idle.
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drive_enable) |-> (o_busy_res && !o_byte_valid &&
                                        !o_response_valid))
        else $error("line driven outside the start sequence");

endmodule

### dv/tb.sv
// Self-checking testbench for the single-wire sensor reader top level.
module tb;
    import swsr_pkg::*;

    // Phases of the link as the testbench tracks them.
    typedef enum logic [3:0] {
        LINK_IDLE,
        LINK_PRE,
        LINK_LOW,
        LINK_REL,
        LINK_CHK1,
        LINK_CHK2,
        LINK_WAIT_OK,
        LINK_WAIT_END,
        LINK_BIT_HIGH,
        LINK_BIT_DELAY,
        LINK_BIT_LOW
    } t_link_phase;

    // One row of the directed sequence.
    typedef struct packed {
        logic    cfg_first;
        logic    start;
        logic    tick;
        logic    pin;
        logic    typed;
        t_result want;
    } t_dir_row;

    localparam t_result RES_IDLE   = '0;
    localparam t_result RES_ABSENT = '{1'b0, 1'b0, 1'b1, STATUS_ABSENT, 8'd0, 1'b0, 1'b0, 1'b1};
    localparam t_result RES_BAD    = '{1'b0, 1'b0, 1'b1, STATUS_BAD, 8'd0, 1'b0, 1'b0, 1'b1};
    localparam t_result RES_OK     = '{1'b0, 1'b0, 1'b1, STATUS_OK, 8'd0, 1'b0, 1'b0, 1'b1};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_start_req;
    logic                i_tick;
    logic                i_pin_level;
    logic                o_valid;
    logic                i_stall;
    logic                o_drive_enable;
    logic                o_drive_level;
    logic                o_response_valid;
    logic [1:0]          o_response_status;
    logic [7:0]          o_data_byte;
    logic                o_byte_valid;
    logic                o_last_byte;
    logic                o_busy_res;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Tracked copy of the link state and its configuration.
    t_cfg                link_cfg;
    t_link_phase         link_phase;
    logic [COUNTER_BITS-1:0] us_count;
    logic [7:0]          shift_reg;
    logic [2:0]          bit_cnt;
    logic [2:0]          byte_cnt;

    // Result words still to come, oldest first.
    t_result             result_q[$];
    int                  mism;

    // Behaviour of the sensor side for the current transaction.
    logic [1:0]          resp_plan;
    int                  tick_pct;
    int                  burst_left;

    int                  stall_mode;
    int                  mode_left;

    t_dir_row            dir_rows [24];

    single_wire_sensor_reader_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_start_req       (i_start_req),
        .i_tick            (i_tick),
        .i_pin_level       (i_pin_level),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_drive_enable    (o_drive_enable),
        .o_drive_level     (o_drive_level),
        .o_response_valid  (o_response_valid),
        .o_response_status (o_response_status),
        .o_data_byte       (o_data_byte),
        .o_byte_valid      (o_byte_valid),
        .o_last_byte       (o_last_byte),
        .o_busy_res        (o_busy_res),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Clock with a period of ten units.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Field-level comparison; only the first ten mismatches are reported.
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mism++;
            if (mism <= 10)
                $display("tb: mismatch in %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Returns the value of one register from a configuration set.
    function automatic logic [31:0] cfg_field(input t_cfg c, input t_reg_idx idx);
        case (idx)
            REG_PRE_IDLE:     return 32'(c.pre_idle_us);
            REG_START_LOW:    return 32'(c.start_low_us);
            REG_RELEASE_HIGH: return 32'(c.release_high_us);
            REG_FIRST_CHECK:  return 32'(c.first_check_us);
            REG_SECOND_CHECK: return 32'(c.second_check_us);
            REG_BIT_SAMPLE:   return 32'(c.bit_sample_us);
            REG_BYTES_FRAME:  return 32'(c.bytes_per_frame);
            default:          return 32'd0;
        endcase
    endfunction

    // Reset state of the tracked link.
    task automatic link_reset();
        link_cfg = '{RST_PRE_IDLE, RST_START_LOW, RST_RELEASE_HIGH, RST_FIRST_CHECK,
                     RST_SECOND_CHECK, RST_BIT_SAMPLE, RST_BYTES_FRAME};
        link_phase = LINK_IDLE;
        us_count = '0;
        shift_reg = '0;
        bit_cnt = '0;
        byte_cnt = '0;
    endtask

    function automatic void link_enter(input t_link_phase ph);
        link_phase = ph;
        us_count = '0;
    endfunction

    // Counts a tick and tells whether the delay of the current phase has run out.
    function automatic logic timer_hit(input logic tk, input logic [CMP_W-1:0] target);
        logic [CMP_W-1:0] lim;
        lim = (target > CMP_W'(CNT_MAX)) ? CMP_W'(CNT_MAX) : target;
        if (tk && us_count != CNT_MAX)
            us_count = us_count + 1'b1;
        return CMP_W'(us_count) >= lim;
    endfunction

    // Advances the tracked link by one sample word and returns its result word.
    function automatic t_result link_predict(input logic s, input logic tk, input logic p);
        t_result    r;
        logic [3:0] frame;
        r = '0;
        frame = link_cfg.bytes_per_frame;
        if (frame == 4'd0)
            frame = 4'd1;
        else if (frame > 4'd8)
            frame = 4'd8;
        case (link_phase)
            LINK_IDLE: if (s) link_enter(LINK_PRE);
            LINK_PRE: if (timer_hit(tk, CMP_W'(link_cfg.pre_idle_us))) link_enter(LINK_LOW);
            LINK_LOW: if (timer_hit(tk, CMP_W'(link_cfg.start_low_us))) link_enter(LINK_REL);
            LINK_REL: if (timer_hit(tk, CMP_W'(link_cfg.release_high_us)))
                link_enter(LINK_CHK1);
            LINK_CHK1: begin
                if (timer_hit(tk, CMP_W'(link_cfg.first_check_us))) begin
                    if (p) begin
                        r.response_valid = 1'b1;
                        r.response_status = STATUS_ABSENT;
                        link_enter(LINK_WAIT_END);
                    end else begin
                        link_enter(LINK_CHK2);
                    end
                end
            end
            LINK_CHK2: begin
                if (timer_hit(tk, CMP_W'(link_cfg.second_check_us))) begin
                    r.response_valid = 1'b1;
                    if (p) begin
                        r.response_status = STATUS_OK;
                        link_enter(LINK_WAIT_OK);
                    end else begin
                        r.response_status = STATUS_BAD;
                        link_enter(LINK_WAIT_END);
                    end
                end
            end
            LINK_WAIT_OK: begin
                if (!p) begin
                    shift_reg = '0;
                    bit_cnt = '0;
                    byte_cnt = '0;
                    link_enter(LINK_BIT_HIGH);
                end
            end
            LINK_WAIT_END: if (!p) link_enter(LINK_IDLE);
            LINK_BIT_HIGH: if (p) link_enter(LINK_BIT_DELAY);
            LINK_BIT_DELAY: begin
                if (timer_hit(tk, CMP_W'(link_cfg.bit_sample_us))) begin
                    shift_reg = {shift_reg[6:0], p};
                    link_enter(LINK_BIT_LOW);
                end
            end
            LINK_BIT_LOW: begin
                if (!p) begin
                    if (bit_cnt == 3'd7) begin
                        r.byte_valid = 1'b1;
                        r.data_byte = shift_reg;
                        r.last_byte = ({1'b0, byte_cnt} + 4'd1 >= frame);
                        bit_cnt = '0;
                        shift_reg = '0;
                        if (r.last_byte) begin
                            byte_cnt = '0;
                            link_enter(LINK_IDLE);
                        end else begin
                            byte_cnt = byte_cnt + 3'd1;
                            link_enter(LINK_BIT_HIGH);
                        end
                    end else begin
                        bit_cnt = bit_cnt + 3'd1;
                        link_enter(LINK_BIT_HIGH);
                    end
                end
            end
            default: link_enter(LINK_IDLE);
        endcase
        r.drive_enable = (link_phase == LINK_PRE) || (link_phase == LINK_LOW) ||
                         (link_phase == LINK_REL);
        r.drive_level = (link_phase == LINK_PRE) || (link_phase == LINK_REL);
        r.busy_res = (link_phase != LINK_IDLE);
        return r;
    endfunction

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PRE_IDLE:     link_cfg.pre_idle_us = val[PRE_W-1:0];
            REG_START_LOW:    link_cfg.start_low_us = val[DELAY_W-1:0];
            REG_RELEASE_HIGH: link_cfg.release_high_us = val[DELAY_W-1:0];
            REG_FIRST_CHECK:  link_cfg.first_check_us = val[DELAY_W-1:0];
            REG_SECOND_CHECK: link_cfg.second_check_us = val[DELAY_W-1:0];
            REG_BIT_SAMPLE:   link_cfg.bit_sample_us = val[DELAY_W-1:0];
            REG_BYTES_FRAME:  link_cfg.bytes_per_frame = val[FRAME_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // APB read, compared with the tracked register value.
    task automatic apb_check(input t_reg_idx idx);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field($sformatf("register %s", idx.name()), cfg_field(link_cfg, idx), prdata);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes a whole configuration set and reads every register back.
    task automatic load_cfg(input t_cfg c);
        for (int i = 0; i < 7; i++)
            apb_write(t_reg_idx'(i), cfg_field(c, t_reg_idx'(i)));
        for (int i = 0; i < 7; i++)
            apb_check(t_reg_idx'(i));
    endtask

    // Offers one sample word, waits until it is taken, and records its result.
    task automatic send_word(input logic s, input logic tk, input logic p,
                             input logic typed, input t_result want);
        t_result r;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_start_req <= s;
        i_tick <= tk;
        i_pin_level <= p;
        do @(posedge i_clk); while (o_stall);
        r = link_predict(s, tk, p);
        result_q.push_back(typed ? want : r);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Holds the sender off until every result word has arrived.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Builds one sample word the way a sensor would answer in the current phase.
    task automatic next_word(input logic allow_start, output logic started);
        logic s;
        logic tk;
        logic p;
        int   pick;
        s = 1'($urandom_range(0, 1));
        tk = ($urandom_range(0, 99) < tick_pct);
        case (link_phase)
            LINK_IDLE:      s = allow_start && ($urandom_range(0, 2) == 0);
            LINK_CHK1:      p = (resp_plan == STATUS_ABSENT);
            LINK_CHK2:      p = (resp_plan == STATUS_OK);
            LINK_WAIT_OK, LINK_WAIT_END, LINK_BIT_LOW:
                            p = ($urandom_range(0, 2) != 0);
            LINK_BIT_HIGH:  p = ($urandom_range(0, 2) == 0);
            default:        p = 1'($urandom_range(0, 1));
        endcase
        if (link_phase == LINK_IDLE)
            p = 1'($urandom_range(0, 1));
        // Now and then the line misbehaves.
        if ($urandom_range(0, 9) == 0)
            p = 1'($urandom_range(0, 1));
        started = (link_phase == LINK_IDLE) && s;
        if (started) begin
            pick = $urandom_range(0, 19);
            resp_plan = (pick < 14) ? STATUS_OK : (pick < 17) ? STATUS_ABSENT : STATUS_BAD;
        end
        send_word(s, tk, p, 1'b0, RES_IDLE);
    endtask

    // Random words in bursts, then the frame in flight is run to its end.
    task automatic run_phase(input int budget, input int pause_at);
        int   n;
        int   starts;
        logic st;
        n = 0;
        starts = 0;
        while (n < budget || starts == 0) begin
            next_word(1'b1, st);
            if (st)
                starts++;
            n++;
            if (n == pause_at)
                settle();
            burst_left--;
            if (burst_left <= 0) begin
                idle_cycles($urandom_range(0, 4));
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 16);
            end
        end
        while (link_phase != LINK_IDLE)
            next_word(1'b0, st);
        settle();
    endtask

    // Result checker: every word taken is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                mism++;
                if (mism <= 10)
                    $display("tb: result word with nothing expected");
            end else begin
                w = result_q.pop_front();
                check_field("drive_enable", w.drive_enable, o_drive_enable);
                check_field("drive_level", w.drive_level, o_drive_level);
                check_field("response_valid", w.response_valid, o_response_valid);
                check_field("response_status", w.response_status, o_response_status);
                check_field("data_byte", w.data_byte, o_data_byte);
                check_field("byte_valid", w.byte_valid, o_byte_valid);
                check_field("last_byte", w.last_byte, o_last_byte);
                check_field("busy_res", w.busy_res, o_busy_res);
            end
        end
    end

    // Receiver stall pattern, switching between randomly chosen modes.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_mode <= 0;
            mode_left <= 0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= ~i_stall;
            endcase
        end
    end

    // Guard against a hung run.
    initial begin
        #100_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Main sequence.
    initial begin
        t_cfg c;
        t_cfg dir_cfg;
        int   frame_pick [6];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_start_req = 1'b0;
        i_tick = 1'b0;
        i_pin_level = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mism = 0;
        tick_pct = 80;
        burst_left = 10;
        resp_plan = STATUS_OK;
        frame_pick = '{0, 1, 3, 15, 2, 8};
        link_reset();

        // Short timings so that a whole transaction fits in a few words.
        dir_cfg = '{21'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0};

        // Reset words, then an absent, a bad and the start of an ok response.
        dir_rows = '{
            '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, RES_IDLE},
            '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, RES_IDLE},
            '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, RES_IDLE},
            '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, RES_ABSENT},
            '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, RES_IDLE},
            '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, RES_BAD},
            '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, RES_IDLE},
            '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, RES_IDLE},
            '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, RES_OK},
            '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, RES_IDLE}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults after reset.
        for (int i = 0; i < 7; i++)
            apb_check(t_reg_idx'(i));

        // Directed sequence.
        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_first) begin
                settle();
                load_cfg(dir_cfg);
            end
            send_word(dir_rows[i].start, dir_rows[i].tick, dir_rows[i].pin,
                      dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases; the first finishes the frame left open above.
        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6) begin
                // A long pre-idle time is only written and read back.
                apb_write(REG_PRE_IDLE, 32'd2000000);
                apb_check(REG_PRE_IDLE);
                c = '{21'd0, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 4'd8};
                tick_pct = 100;
                load_cfg(c);
            end else if (ph > 0) begin
                c.pre_idle_us = PRE_W'($urandom_range(0, 4));
                c.start_low_us = DELAY_W'($urandom_range(1, 4));
                c.release_high_us = DELAY_W'($urandom_range(0, 3));
                c.first_check_us = DELAY_W'($urandom_range(0, 3));
                c.second_check_us = DELAY_W'($urandom_range(0, 3));
                c.bit_sample_us = DELAY_W'($urandom_range(0, 3));
                c.bytes_per_frame = (ph == 5) ? FRAME_W'($urandom_range(1, 8))
                                              : FRAME_W'(frame_pick[ph]);
                tick_pct = $urandom_range(60, 100);
                load_cfg(c);
            end
            run_phase((ph == 6) ? 5 : 90, (ph == 2) ? 40 : -1);
        end

        settle();
        if (mism == 0 && result_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### files.f
hw/rtl/swsr_pkg.sv
hw/rtl/swsr_regs.sv
hw/rtl/swsr_seq.sv
hw/rtl/single_wire_sensor_reader_top.sv
dv/tb.sv
